### rtl/rptc_pkg.sv
// Shared types, constants and register codes for the pointer ray to canvas pixel core.
// Used by every module of the core; depends on nothing else.
package rptc_pkg;

	localparam int COORD_W   = 32;
	localparam int AXIS_W    = 16;
	localparam int ROW_W     = 48;
	localparam int PIX_W     = 18;
	localparam int CFG_IDX_W = 4;
	localparam int QUOT_W    = 64;
	localparam int DEN_W     = 32;

	localparam int PIXEL_WIDTH_DEF  = 1024;
	localparam int PIXEL_HEIGHT_DEF = 1024;

	localparam logic [PIX_W-1:0] PIX_MAX = 18'h3FFFF;

	localparam logic [ROW_W-1:0]   ROT_X_RST  = 48'h4000_0000_0000;
	localparam logic [ROW_W-1:0]   ROT_Y_RST  = 48'h0000_4000_0000;
	localparam logic [ROW_W-1:0]   ROT_Z_RST  = 48'h0000_0000_4000;
	localparam logic [COORD_W-1:0] SIZE_RST   = 32'h0001_0000;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ROT_X   = 4'd0,
		CFG_ROT_Y   = 4'd1,
		CFG_ROT_Z   = 4'd2,
		CFG_SHIFT_X = 4'd3,
		CFG_SHIFT_Y = 4'd4,
		CFG_SHIFT_Z = 4'd5,
		CFG_WIDTH   = 4'd6,
		CFG_HEIGHT  = 4'd7
	} cfg_idx_t;

	// Per-item data that rides along the quotient pipeline.
	typedef struct packed {
		logic                      neg_x;
		logic                      neg_y;
		logic signed [COORD_W-1:0] px;
		logic signed [COORD_W-1:0] py;
	} hit_side_t;

endpackage

### rtl/rptc_xform.sv
// Three-stage transform front end: rotates and shifts the pose into the canvas frame.
// Depends on rptc_pkg.
module rptc_xform
	import rptc_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic                      in_take,
	input  logic signed [COORD_W-1:0] pos_x,
	input  logic signed [COORD_W-1:0] pos_y,
	input  logic signed [COORD_W-1:0] pos_z,
	input  logic signed [AXIS_W-1:0]  axis_x,
	input  logic signed [AXIS_W-1:0]  axis_y,
	input  logic signed [AXIS_W-1:0]  axis_z,
	input  logic [ROW_W-1:0]          rot_x,
	input  logic [ROW_W-1:0]          rot_y,
	input  logic [ROW_W-1:0]          rot_z,
	input  logic signed [COORD_W-1:0] shift_x,
	input  logic signed [COORD_W-1:0] shift_y,
	input  logic signed [COORD_W-1:0] shift_z,
	output logic                      out_vld,
	output hit_side_t                 out_side,
	output logic [QUOT_W-1:0]         num_x,
	output logic [QUOT_W-1:0]         num_y,
	output logic [DEN_W-1:0]          den
);

	logic                     vld_s1;
	logic signed [47:0]       pp_s1 [0:2][0:2];
	logic signed [31:0]       dp_s1 [0:2][0:2];
	logic                     vld_s2;
	logic signed [31:0]       p_s2 [0:2];
	logic signed [33:0]       d_s2 [0:2];
	logic                     vld_s3;
	hit_side_t                side_s3;
	logic [QUOT_W-1:0]        nx_s3;
	logic [QUOT_W-1:0]        ny_s3;
	logic [DEN_W-1:0]         den_s3;

	logic [ROW_W-1:0]         rows [0:2];
	logic signed [COORD_W-1:0] shifts [0:2];
	logic signed [COORD_W-1:0] pos [0:2];
	logic signed [AXIS_W-1:0]  ax [0:2];

	assign rows   = '{rot_x, rot_y, rot_z};
	assign shifts = '{shift_x, shift_y, shift_z};
	assign pos    = '{pos_x, pos_y, pos_z};
	assign ax     = '{axis_x, axis_y, axis_z};

	// Stage 1: the three products of each of the six dot products (position and axis).
	for (genvar r = 0; r < 3; r++) begin : g_row
		for (genvar c = 0; c < 3; c++) begin : g_col
			logic signed [AXIS_W-1:0] ent;
			assign ent = rows[r][ROW_W-1-AXIS_W*c -: AXIS_W];
			always_ff @(posedge clk) begin
				if (en) begin
					pp_s1[r][c] <= 48'(ent) * 48'(pos[c]);
					dp_s1[r][c] <= 32'(ent) * 32'(ax[c]);
				end
			end
		end
	end

	// Stage 2: sums, floor to Q16.16, translation and saturation.
	for (genvar r = 0; r < 3; r++) begin : g_sum
		logic signed [49:0] sp;
		logic signed [35:0] fl;
		logic signed [36:0] tp;
		logic signed [31:0] sat;
		always_comb begin
			sp = 50'(pp_s1[r][0]) + 50'(pp_s1[r][1]) + 50'(pp_s1[r][2]);
			fl = 36'(sp >>> 14);
			tp = 37'(fl) + 37'(shifts[r]);
			if (tp > 37'sh0_7FFF_FFFF) begin
				sat = 32'sh7FFF_FFFF;
			end else if (tp < -37'sh0_8000_0000) begin
				sat = 32'sh8000_0000;
			end else begin
				sat = 32'(tp);
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				p_s2[r] <= sat;
				d_s2[r] <= 34'(dp_s1[r][0]) + 34'(dp_s1[r][1]) + 34'(dp_s1[r][2]);
			end
		end
	end

	// Stage 3: drop items on or behind the canvas or parallel to it, then form magnitudes.
	logic [31:0] mag_dx, mag_dy, mag_dz, pz_u;
	logic        keep;
	always_comb begin
		mag_dx = 32'(d_s2[0][33] ? -d_s2[0] : d_s2[0]);
		mag_dy = 32'(d_s2[1][33] ? -d_s2[1] : d_s2[1]);
		mag_dz = 32'(d_s2[2][33] ? -d_s2[2] : d_s2[2]);
		pz_u   = 32'(p_s2[2]);
		keep   = !p_s2[2][31] && (p_s2[2] != '0) && (d_s2[2] != '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_take;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2 && keep;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s3.neg_x <= d_s2[0][33] ^ d_s2[2][33];
			side_s3.neg_y <= d_s2[1][33] ^ d_s2[2][33];
			side_s3.px    <= p_s2[0];
			side_s3.py    <= p_s2[1];
			nx_s3         <= 64'(mag_dx) * 64'(pz_u);
			ny_s3         <= 64'(mag_dy) * 64'(pz_u);
			den_s3        <= mag_dz;
		end
	end

	assign out_vld  = vld_s3;
	assign out_side = side_s3;
	assign num_x    = nx_s3;
	assign num_y    = ny_s3;
	assign den      = den_s3;

endmodule

### rtl/rptc_quot.sv
// Pipelined restoring divider, one quotient bit per stage, two lanes over one divisor.
// Depends on rptc_pkg for the side data type.
module rptc_quot
	import rptc_pkg::*;
#(
	parameter int NUM_W = QUOT_W,
	parameter int DIV_W = DEN_W
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_vld,
	input  hit_side_t        in_side,
	input  logic [NUM_W-1:0] num_x,
	input  logic [NUM_W-1:0] num_y,
	input  logic [DIV_W-1:0] den,
	output logic             out_vld,
	output hit_side_t        out_side,
	output logic [NUM_W-1:0] quot_x,
	output logic [NUM_W-1:0] quot_y
);

	logic             vld_s  [0:NUM_W];
	hit_side_t        side_s [0:NUM_W];
	logic [DIV_W-1:0] den_s  [0:NUM_W];
	logic [DIV_W-1:0] remx_s [0:NUM_W];
	logic [DIV_W-1:0] remy_s [0:NUM_W];
	logic [NUM_W-1:0] accx_s [0:NUM_W];
	logic [NUM_W-1:0] accy_s [0:NUM_W];

	assign vld_s[0]  = in_vld;
	assign side_s[0] = in_side;
	assign den_s[0]  = den;
	assign remx_s[0] = '0;
	assign remy_s[0] = '0;
	assign accx_s[0] = num_x;
	assign accy_s[0] = num_y;

	for (genvar k = 0; k < NUM_W; k++) begin : g_step
		logic [DIV_W:0] tx, ty;
		logic           bx, by;
		assign tx = {remx_s[k], accx_s[k][NUM_W-1]};
		assign ty = {remy_s[k], accy_s[k][NUM_W-1]};
		assign bx = tx >= {1'b0, den_s[k]};
		assign by = ty >= {1'b0, den_s[k]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				side_s[k+1] <= side_s[k];
				den_s[k+1]  <= den_s[k];
				remx_s[k+1] <= bx ? DIV_W'(tx - {1'b0, den_s[k]}) : tx[DIV_W-1:0];
				remy_s[k+1] <= by ? DIV_W'(ty - {1'b0, den_s[k]}) : ty[DIV_W-1:0];
				accx_s[k+1] <= {accx_s[k][NUM_W-2:0], bx};
				accy_s[k+1] <= {accy_s[k][NUM_W-2:0], by};
			end
		end
	end

	assign out_vld  = vld_s[NUM_W];
	assign out_side = side_s[NUM_W];
	assign quot_x   = accx_s[NUM_W];
	assign quot_y   = accy_s[NUM_W];

endmodule

### rtl/rptc_pixdiv.sv
// Pipelined divider that scales hit coordinates by the canvas size into pixels.
// Depends on rptc_pkg for widths.
module rptc_pixdiv
	import rptc_pkg::*;
#(
	parameter int QB = 18
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  in_vld,
	input  logic [DEN_W+QB-1:0]   num_x,
	input  logic [DEN_W+QB-1:0]   num_y,
	input  logic [DEN_W-1:0]      den_x,
	input  logic [DEN_W-1:0]      den_y,
	output logic                  out_vld,
	output logic [QB-1:0]         quot_x,
	output logic [QB-1:0]         quot_y
);

	// The quotient is known to fit in QB bits, so the upper dividend part
	// starts as the remainder and only QB steps are needed.
	logic             vld_s  [0:QB];
	logic [DEN_W-1:0] remx_s [0:QB];
	logic [DEN_W-1:0] remy_s [0:QB];
	logic [QB-1:0]    accx_s [0:QB];
	logic [QB-1:0]    accy_s [0:QB];

	assign vld_s[0]  = in_vld;
	assign remx_s[0] = num_x[DEN_W+QB-1:QB];
	assign remy_s[0] = num_y[DEN_W+QB-1:QB];
	assign accx_s[0] = num_x[QB-1:0];
	assign accy_s[0] = num_y[QB-1:0];

	for (genvar k = 0; k < QB; k++) begin : g_step
		logic [DEN_W:0] tx, ty;
		logic           bx, by;
		assign tx = {remx_s[k], accx_s[k][QB-1]};
		assign ty = {remy_s[k], accy_s[k][QB-1]};
		assign bx = tx >= {1'b0, den_x};
		assign by = ty >= {1'b0, den_y};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				remx_s[k+1] <= bx ? DEN_W'(tx - {1'b0, den_x}) : tx[DEN_W-1:0];
				remy_s[k+1] <= by ? DEN_W'(ty - {1'b0, den_y}) : ty[DEN_W-1:0];
				accx_s[k+1] <= {accx_s[k][QB-2:0], bx};
				accy_s[k+1] <= {accy_s[k][QB-2:0], by};
			end
		end
	end

	assign out_vld = vld_s[QB];
	assign quot_x  = accx_s[QB];
	assign quot_y  = accy_s[QB];

endmodule

### rtl/pointer_ray_to_canvas_pixel_core.sv
// Top level of the pointer ray to canvas pixel core: registers, hit test and output stage.
// Depends on rptc_pkg, rptc_xform, rptc_quot and rptc_pixdiv.
//
// Usage: software writes the inverse canvas transform and the canvas size through the
// configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) while no item is in
// flight; cfg_ready is always high and an unknown index is ignored. Pose items arrive on
// the input channel (in_valid/in_stall) and hits leave on the output channel
// (out_valid/out_stall). An item whose ray misses the canvas, starts behind it or runs
// parallel to it produces no output item.
// Throughput is one item per cycle while in_stall is low. The ray parameter divider has
// 64 one-bit stages and the pixel scaling divider has QB stages, where QB = 8 +
// clog2(max(PIXEL_WIDTH, PIXEL_HEIGHT)); together they make up most of the pipeline.
// When the receiver stalls, the output register holds its item and one more finished
// item parks in a skid register; only then does in_stall rise and the whole pipeline
// freeze in place, so nothing is lost or repeated.
// Reset clears all valid bits and loads the identity transform and a 1.0 x 1.0 canvas.
module pointer_ray_to_canvas_pixel_core
	import rptc_pkg::*;
#(
	parameter int PIXEL_WIDTH  = PIXEL_WIDTH_DEF,
	parameter int PIXEL_HEIGHT = PIXEL_HEIGHT_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [CFG_IDX_W-1:0]      cfg_index,
	input  logic [ROW_W-1:0]          cfg_data,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic signed [COORD_W-1:0] dev_pos_x,
	input  logic signed [COORD_W-1:0] dev_pos_y,
	input  logic signed [COORD_W-1:0] dev_pos_z,
	input  logic signed [AXIS_W-1:0]  dev_axis_x,
	input  logic signed [AXIS_W-1:0]  dev_axis_y,
	input  logic signed [AXIS_W-1:0]  dev_axis_z,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [PIX_W-1:0]          pixel_x,
	output logic [PIX_W-1:0]          pixel_y
);

	localparam int PIX_MAXDIM = (PIXEL_WIDTH > PIXEL_HEIGHT) ? PIXEL_WIDTH : PIXEL_HEIGHT;
	localparam int QB         = 8 + $clog2(PIX_MAXDIM);
	localparam int NW         = DEN_W + QB;
	localparam int CW         = (QB > PIX_W) ? QB : PIX_W;
	localparam logic [QB:0] SCALE_X = (QB+1)'(PIXEL_WIDTH * 256);
	localparam logic [QB:0] SCALE_Y = (QB+1)'(PIXEL_HEIGHT * 256);

	// Configuration registers.
	logic [ROW_W-1:0]          rot_x_q, rot_y_q, rot_z_q;
	logic signed [COORD_W-1:0] shift_x_q, shift_y_q, shift_z_q;
	logic [COORD_W-1:0]        width_q, height_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rot_x_q   <= ROT_X_RST;
			rot_y_q   <= ROT_Y_RST;
			rot_z_q   <= ROT_Z_RST;
			shift_x_q <= '0;
			shift_y_q <= '0;
			shift_z_q <= '0;
			width_q   <= SIZE_RST;
			height_q  <= SIZE_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_ROT_X:   rot_x_q   <= cfg_data;
				CFG_ROT_Y:   rot_y_q   <= cfg_data;
				CFG_ROT_Z:   rot_z_q   <= cfg_data;
				CFG_SHIFT_X: shift_x_q <= cfg_data[COORD_W-1:0];
				CFG_SHIFT_Y: shift_y_q <= cfg_data[COORD_W-1:0];
				CFG_SHIFT_Z: shift_z_q <= cfg_data[COORD_W-1:0];
				CFG_WIDTH:   width_q   <= cfg_data[COORD_W-1:0];
				CFG_HEIGHT:  height_q  <= cfg_data[COORD_W-1:0];
				default: ;
			endcase
		end
	end

	// The whole pipeline advances together unless the skid register is occupied.
	logic skid_full_q;
	logic en;
	assign en       = !skid_full_q;
	assign in_stall = skid_full_q;

	logic              xf_vld;
	hit_side_t         xf_side;
	logic [QUOT_W-1:0] xf_num_x, xf_num_y;
	logic [DEN_W-1:0]  xf_den;

	rptc_xform u_xform (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_take  (in_valid && !in_stall),
		.pos_x    (dev_pos_x),
		.pos_y    (dev_pos_y),
		.pos_z    (dev_pos_z),
		.axis_x   (dev_axis_x),
		.axis_y   (dev_axis_y),
		.axis_z   (dev_axis_z),
		.rot_x    (rot_x_q),
		.rot_y    (rot_y_q),
		.rot_z    (rot_z_q),
		.shift_x  (shift_x_q),
		.shift_y  (shift_y_q),
		.shift_z  (shift_z_q),
		.out_vld  (xf_vld),
		.out_side (xf_side),
		.num_x    (xf_num_x),
		.num_y    (xf_num_y),
		.den      (xf_den)
	);

	logic              qt_vld;
	hit_side_t         qt_side;
	logic [QUOT_W-1:0] qt_x, qt_y;

	rptc_quot #(
		.NUM_W (QUOT_W),
		.DIV_W (DEN_W)
	) u_quot (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (xf_vld),
		.in_side  (xf_side),
		.num_x    (xf_num_x),
		.num_y    (xf_num_y),
		.den      (xf_den),
		.out_vld  (qt_vld),
		.out_side (qt_side),
		.quot_x   (qt_x),
		.quot_y   (qt_y)
	);

	// Hit point and strict bounds test, then scaling of the hit into the pixel numerator.
	logic signed [65:0] off_x, off_y, hit_x, hit_y, neg_hy;
	logic               in_rect;
	logic [31:0]        hx_lo, hy_lo;

	always_comb begin
		off_x  = qt_side.neg_x ? -$signed({2'b00, qt_x}) : $signed({2'b00, qt_x});
		off_y  = qt_side.neg_y ? -$signed({2'b00, qt_y}) : $signed({2'b00, qt_y});
		hit_x  = 66'(qt_side.px) - off_x;
		hit_y  = 66'(qt_side.py) - off_y;
		neg_hy = -hit_y;
		in_rect = (hit_x > 66'sd0) && (hit_x < $signed({34'b0, width_q}))
			&& (hit_y < 66'sd0) && (neg_hy < $signed({34'b0, height_q}));
		hx_lo  = hit_x[31:0];
		hy_lo  = neg_hy[31:0];
	end

	logic          vld_s4;
	logic [NW-1:0] scx_s4, scy_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s4 <= qt_vld && in_rect;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			scx_s4 <= NW'(NW'(hx_lo) * NW'(SCALE_X));
			scy_s4 <= NW'(NW'(hy_lo) * NW'(SCALE_Y));
		end
	end

	logic          pd_vld;
	logic [QB-1:0] pd_x, pd_y;

	rptc_pixdiv #(
		.QB (QB)
	) u_pixdiv (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (vld_s4),
		.num_x   (scx_s4),
		.num_y   (scy_s4),
		.den_x   (width_q),
		.den_y   (height_q),
		.out_vld (pd_vld),
		.quot_x  (pd_x),
		.quot_y  (pd_y)
	);

	// Pixel values above the 18-bit range saturate.
	logic [PIX_W-1:0] sat_x, sat_y;
	always_comb begin
		sat_x = (CW'(pd_x) > CW'(PIX_MAX)) ? PIX_MAX : PIX_W'(pd_x);
		sat_y = (CW'(pd_y) > CW'(PIX_MAX)) ? PIX_MAX : PIX_W'(pd_y);
	end

	// Output register plus one skid entry.
	logic             out_valid_q;
	logic [PIX_W-1:0] out_x_q, out_y_q, skid_x_q, skid_y_q;
	logic             out_take;

	assign out_take = out_valid_q && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			skid_full_q <= 1'b0;
		end else if (skid_full_q) begin
			if (out_take) begin
				skid_full_q <= 1'b0;
			end
		end else if (pd_vld) begin
			if (out_valid_q && !out_take) begin
				skid_full_q <= 1'b1;
			end else begin
				out_valid_q <= 1'b1;
			end
		end else if (out_take) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_full_q) begin
			if (out_take) begin
				out_x_q <= skid_x_q;
				out_y_q <= skid_y_q;
			end
		end else if (pd_vld) begin
			if (out_valid_q && !out_take) begin
				skid_x_q <= sat_x;
				skid_y_q <= sat_y;
			end else begin
				out_x_q <= sat_x;
				out_y_q <= sat_y;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign pixel_x   = out_x_q;
	assign pixel_y   = out_y_q;

endmodule

### rtl/rptc_checker.sv
// Port-level checks for the pointer ray to canvas pixel core, bound to the top level.
// Depends on rptc_pkg and pointer_ray_to_canvas_pixel_core.
module rptc_checker
	import rptc_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               cfg_ready,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input logic [PIX_W-1:0]   pixel_x,
	input logic [PIX_W-1:0]   pixel_y
);

	// A stalled result stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	// A stalled result keeps its payload.
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(pixel_x) && $stable(pixel_y))
		else $error("result payload changed while stalled");

	// The input only backs up behind a stalled, occupied output.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(in_stall) |-> $past(out_valid && out_stall))
		else $error("input stalled without a stalled output");

	// An empty output stage never coexists with input back pressure.
	a_stall_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled while output is empty");

	// Configuration writes are always taken.
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready)
		else $error("configuration port not ready");

endmodule

bind pointer_ray_to_canvas_pixel_core rptc_checker u_rptc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.cfg_ready (cfg_ready),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.pixel_x   (pixel_x),
	.pixel_y   (pixel_y)
);

### tb/sv/testbench.sv
// Self-checking testbench for pointer_ray_to_canvas_pixel_core: a driver and a monitor around the
// core, with an in-bench predictor of the ray-to-canvas hit test and pixel scaling.
// Depends on rptc_pkg and the core RTL only.
module testbench
	import rptc_pkg::*;
;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int PIX_WIDTH_TB  = PIXEL_WIDTH_DEF;
	localparam int PIX_HEIGHT_TB = PIXEL_HEIGHT_DEF;
	// Idle cycles after the last result before the core is reconfigured; the pipeline is 87 deep.
	localparam int DRAIN_CYCLES  = 120;
	// The receiver's forced hold-off in cycles, long enough to fill the whole pipeline.
	localparam int HOLD_CYCLES   = 400;
	// Cycles with no handshake of any kind before the run is declared hung.
	localparam int STUCK_LIMIT   = 6000;

	typedef struct packed {
		logic signed [COORD_W-1:0] pos_x;
		logic signed [COORD_W-1:0] pos_y;
		logic signed [COORD_W-1:0] pos_z;
		logic signed [AXIS_W-1:0]  axis_x;
		logic signed [AXIS_W-1:0]  axis_y;
		logic signed [AXIS_W-1:0]  axis_z;
	} pose_t;

	typedef struct packed {
		logic [PIX_W-1:0] px;
		logic [PIX_W-1:0] py;
	} pixel_t;

	logic                      clk;
	logic                      arst_n;
	logic                      cfg_valid;
	logic                      cfg_ready;
	logic [CFG_IDX_W-1:0]      cfg_index;
	logic [ROW_W-1:0]          cfg_data;
	logic                      in_valid;
	logic                      in_stall;
	logic signed [COORD_W-1:0] dev_pos_x, dev_pos_y, dev_pos_z;
	logic signed [AXIS_W-1:0]  dev_axis_x, dev_axis_y, dev_axis_z;
	logic                      out_valid;
	logic                      out_stall;
	logic [PIX_W-1:0]          pixel_x, pixel_y;

	pointer_ray_to_canvas_pixel_core #(
		.PIXEL_WIDTH(PIX_WIDTH_TB),
		.PIXEL_HEIGHT(PIX_HEIGHT_TB)
	) dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.dev_pos_x(dev_pos_x), .dev_pos_y(dev_pos_y), .dev_pos_z(dev_pos_z),
		.dev_axis_x(dev_axis_x), .dev_axis_y(dev_axis_y), .dev_axis_z(dev_axis_z),
		.out_valid(out_valid), .out_stall(out_stall), .pixel_x(pixel_x), .pixel_y(pixel_y)
	);

	// The bench's own copy of the configuration registers, updated on every accepted write.
	logic [ROW_W-1:0] rot_x, rot_y, rot_z;
	longint           shift_x, shift_y, shift_z;
	longint unsigned  width_q16, height_q16;

	pose_t  pending_poses[$];
	pixel_t expected_pixels[$];
	int     mismatches;
	int     send_gap;
	int     stall_left;
	int     hold_count;
	bit     hold_req, hold_done;
	bit     send_idle_on, recv_idle_on;

	initial clk = 1'b0;
	always #4 clk = ~clk;

	// One signed Q2.14 rotation entry; column 0 sits in the top 16 bits of a row.
	function automatic longint rot_entry(logic [ROW_W-1:0] row, int col);
		logic signed [AXIS_W-1:0] e;
		e = row[ROW_W-1-16*col -: 16];
		return longint'(e);
	endfunction

	function automatic longint row_dot(logic [ROW_W-1:0] row, longint a, longint b, longint c);
		return rot_entry(row, 0) * a + rot_entry(row, 1) * b + rot_entry(row, 2) * c;
	endfunction

	// Canvas-frame position: floor the Q18.30 product back to Q16.16, add the shift, saturate.
	function automatic longint to_canvas(logic [ROW_W-1:0] row, longint shift, pose_t p);
		longint v;
		v = (row_dot(row, p.pos_x, p.pos_y, p.pos_z) >>> 14) + shift;
		if (v > 64'sd2147483647)
			v = 64'sd2147483647;
		else if (v < -64'sd2147483648)
			v = -64'sd2147483648;
		return v;
	endfunction

	function automatic logic [PIX_W-1:0] scale_pixel(longint unsigned v, longint unsigned pix,
			longint unsigned size);
		longint unsigned r;
		r = (v * pix * 64'd256) / size;
		return (r > longint'(PIX_MAX)) ? PIX_MAX : r[PIX_W-1:0];
	endfunction

	// Returns 1 when the ray hits the open canvas rectangle and gives the pixel coordinates.
	function automatic bit predict_pixel(input pose_t p, output pixel_t hit);
		longint cx, cy, cz, dx, dy, dz, hx, hy;
		hit = '0;
		cx = to_canvas(rot_x, shift_x, p);
		cy = to_canvas(rot_y, shift_y, p);
		cz = to_canvas(rot_z, shift_z, p);
		// Pointer behind or on the canvas plane.
		if (cz <= 0)
			return 1'b0;
		dx = row_dot(rot_x, p.axis_x, p.axis_y, p.axis_z);
		dy = row_dot(rot_y, p.axis_x, p.axis_y, p.axis_z);
		dz = row_dot(rot_z, p.axis_x, p.axis_y, p.axis_z);
		// Ray parallel to the plane.
		if (dz == 0)
			return 1'b0;
		// SystemVerilog integer division truncates toward zero, as the hardware does.
		hx = cx - (dx * cz) / dz;
		hy = cy - (dy * cz) / dz;
		// Strict bounds: a hit on the border, or any hit on a zero-size canvas, is a miss.
		if (hx <= 0 || hx >= longint'(width_q16))
			return 1'b0;
		if (hy >= 0 || hy <= -longint'(height_q16))
			return 1'b0;
		hit.px = scale_pixel(hx, 64'(PIX_WIDTH_TB), width_q16);
		hit.py = scale_pixel(-hy, 64'(PIX_HEIGHT_TB), height_q16);
		return 1'b1;
	endfunction

	function automatic void apply_register(logic [CFG_IDX_W-1:0] idx, logic [ROW_W-1:0] data);
		case (idx)
			CFG_ROT_X: begin
				rot_x = data;
			end
			CFG_ROT_Y: begin
				rot_y = data;
			end
			CFG_ROT_Z: begin
				rot_z = data;
			end
			CFG_SHIFT_X: begin
				shift_x = longint'($signed(data[31:0]));
			end
			CFG_SHIFT_Y: begin
				shift_y = longint'($signed(data[31:0]));
			end
			CFG_SHIFT_Z: begin
				shift_z = longint'($signed(data[31:0]));
			end
			CFG_WIDTH: begin
				width_q16 = 64'(data[31:0]);
			end
			CFG_HEIGHT: begin
				height_q16 = 64'(data[31:0]);
			end
			default: begin
				// Unknown indexes are ignored by the core.
			end
		endcase
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 15);
		return $urandom_range(20, 60);
	endfunction

	function automatic int signed_span(int span);
		return int'($urandom_range(0, 2 * span)) - span;
	endfunction

	function automatic pose_t make_pose(logic signed [31:0] x, logic signed [31:0] y,
			logic signed [31:0] z, logic signed [15:0] ax, logic signed [15:0] ay,
			logic signed [15:0] az);
		pose_t p;
		p.pos_x = x; p.pos_y = y; p.pos_z = z;
		p.axis_x = ax; p.axis_y = ay; p.axis_z = az;
		return p;
	endfunction

	// Appends one pose to the driver's queue.
	function automatic void add_pose(pose_t p);
		pending_poses.insert(pending_poses.size(), p);
	endfunction

	// Mostly poses that hit the canvas under the current setting, found by retrying near-canvas
	// candidates; the rest are fully random noise that almost always misses.
	function automatic pose_t random_pose();
		pose_t  p;
		pixel_t dummy;
		int     span;
		if ($urandom_range(0, 3) == 0)
			return make_pose($urandom, $urandom, $urandom, 16'($urandom), 16'($urandom),
				16'($urandom));
		for (int i = 0; i < 40; i++) begin
			span = (i < 20) ? (1 << 17) : (1 << 22);
			p = make_pose(signed_span(span), signed_span(span), signed_span(span),
				16'(signed_span(20000)), 16'(signed_span(20000)), 16'(signed_span(20000)));
			if (predict_pixel(p, dummy))
				break;
		end
		return p;
	endfunction

	// Register writes happen only while the core is idle.
	task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [ROW_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		apply_register(idx, data);
	endtask

	task automatic set_canvas(logic [ROW_W-1:0] rx, logic [ROW_W-1:0] ry, logic [ROW_W-1:0] rz,
			logic [31:0] sx, logic [31:0] sy, logic [31:0] sz, logic [31:0] w, logic [31:0] h);
		write_register(CFG_ROT_X, rx);
		write_register(CFG_ROT_Y, ry);
		write_register(CFG_ROT_Z, rz);
		write_register(CFG_SHIFT_X, {16'h0, sx});
		write_register(CFG_SHIFT_Y, {16'h0, sy});
		write_register(CFG_SHIFT_Z, {16'h0, sz});
		write_register(CFG_WIDTH, {16'h0, w});
		write_register(CFG_HEIGHT, {16'h0, h});
		// An index past the register file must change nothing.
		write_register(CFG_IDX_W'($urandom_range(8, 15)), ROW_W'({$urandom, $urandom}));
		cfg_valid <= 1'b0;
	endtask

	task automatic run_random(int count);
		send_idle_on = ($urandom_range(0, 4) != 0);
		recv_idle_on = ($urandom_range(0, 4) != 0);
		for (int i = 0; i < count; i++)
			add_pose(random_pose());
	endtask

	// Wait until every item is sent and every hit has arrived, then let misses drain out.
	task automatic drain();
		while (pending_poses.size() != 0 || in_valid || expected_pixels.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Driver: presents queued poses, with random gaps between items.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			send_gap = 0;
		end else if (!in_valid || !in_stall) begin
			if (send_gap > 0) begin
				send_gap--;
				in_valid <= 1'b0;
			end else if (pending_poses.size() != 0) begin
				pose_t p;
				p = pending_poses.pop_front();
				dev_pos_x  <= p.pos_x;
				dev_pos_y  <= p.pos_y;
				dev_pos_z  <= p.pos_z;
				dev_axis_x <= p.axis_x;
				dev_axis_y <= p.axis_y;
				dev_axis_z <= p.axis_z;
				in_valid   <= 1'b1;
				send_gap = send_idle_on ? pick_gap() : 0;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Predictor: every accepted pose is evaluated with the configuration in force.
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall) begin
			pixel_t hit;
			if (predict_pixel(make_pose(dev_pos_x, dev_pos_y, dev_pos_z,
					dev_axis_x, dev_axis_y, dev_axis_z), hit))
				expected_pixels.insert(expected_pixels.size(), hit);
		end
	end

	// Receiver: random stalls, plus one long hold-off that backs the pipeline up to the input.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left = 0;
			hold_count = 0;
			hold_done = 1'b0;
		end else if (hold_req && !hold_done) begin
			out_stall <= 1'b1;
			hold_count++;
			if (hold_count >= HOLD_CYCLES)
				hold_done = 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else if (recv_idle_on && $urandom_range(0, 3) == 0) begin
			stall_left = pick_gap();
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// Monitor: each accepted hit is checked against the oldest predicted hit.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_pixels.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected hit: pixel_x=%0d pixel_y=%0d", pixel_x, pixel_y);
			end else begin
				pixel_t want;
				want = expected_pixels.pop_front();
				if (pixel_x !== want.px || pixel_y !== want.py) begin
					mismatches++;
					if (mismatches <= 10)
						$display("hit mismatch: expected (%0d, %0d), got (%0d, %0d)",
							want.px, want.py, pixel_x, pixel_y);
				end
			end
		end
	end

	// Watchdog: any handshake resets the count of quiet cycles.
	int quiet_cycles;
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
				|| (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STUCK_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		dev_pos_x = '0; dev_pos_y = '0; dev_pos_z = '0;
		dev_axis_x = '0; dev_axis_y = '0; dev_axis_z = '0;
		mismatches = 0;
		hold_req = 1'b0;
		send_idle_on = 1'b1;
		recv_idle_on = 1'b1;
		apply_register(CFG_ROT_X, ROT_X_RST);
		apply_register(CFG_ROT_Y, ROT_Y_RST);
		apply_register(CFG_ROT_Z, ROT_Z_RST);
		apply_register(CFG_SHIFT_X, '0);
		apply_register(CFG_SHIFT_Y, '0);
		apply_register(CFG_SHIFT_Z, '0);
		apply_register(CFG_WIDTH, ROW_W'(SIZE_RST));
		apply_register(CFG_HEIGHT, ROW_W'(SIZE_RST));
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed poses against the reset setting: identity transform, 1.0 x 1.0 canvas.
		add_pose(make_pose(32'sh8000, -32'sh8000, 32'sh10000, 0, 0, 16'sh4000));
		add_pose(make_pose(1, -1, 32'sh10000, 0, 0, 16'sh4000));
		add_pose(make_pose(32'shFFFF, -32'shFFFF, 32'sh10000, 0, 0, 16'sh4000));
		// Hits exactly on each border miss.
		add_pose(make_pose(0, -32'sh8000, 32'sh10000, 0, 0, 16'sh4000));
		add_pose(make_pose(32'sh10000, -32'sh8000, 32'sh10000, 0, 0, 16'sh4000));
		add_pose(make_pose(32'sh8000, 0, 32'sh10000, 0, 0, 16'sh4000));
		add_pose(make_pose(32'sh8000, -32'sh10000, 32'sh10000, 0, 0, 16'sh4000));
		// Pointer on and behind the plane.
		add_pose(make_pose(32'sh8000, -32'sh8000, 0, 0, 0, 16'sh4000));
		add_pose(make_pose(32'sh8000, -32'sh8000, -32'sh10000, 0, 0, 16'sh4000));
		// Axis parallel to the plane.
		add_pose(make_pose(32'sh8000, -32'sh8000, 32'sh10000, 16'sh4000, 0, 0));
		// Slanted rays, one landing inside and one with negative z axis.
		add_pose(make_pose(0, 0, 32'sh10000, -16'sh1000, 16'sh1000, 16'sh4000));
		add_pose(make_pose(32'sh8000, -32'sh8000, 32'sh100, 16'sh0100,
			-16'sh0100, -16'sh4000));
		// Field extremes.
		add_pose(make_pose(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF,
			16'sh7FFF, 16'sh7FFF, 16'sh7FFF));
		add_pose(make_pose(-32'sh80000000, -32'sh80000000, -32'sh80000000,
			-16'sh8000, -16'sh8000, -16'sh8000));
		add_pose(make_pose(32'sh4000, -32'sh4000, 32'sh7FFFFFFF,
			16'sh7FFF, -16'sh8000, 16'sh7FFF));
		add_pose(make_pose(32'sh4000, -32'sh4000, 1, -16'sh8000, 16'sh7FFF,
			-16'sh8000));
		add_pose(make_pose(32'sh4000, -32'sh4000, 32'sh10, 0, 0, 1));
		run_random(230);
		drain();

		// Identity with a larger canvas and small shifts; the long hold-off happens here.
		set_canvas(ROT_X_RST, ROT_Y_RST, ROT_Z_RST, signed_span(1 << 16), signed_span(1 << 16),
			$urandom_range(0, 1 << 17), $urandom_range(1 << 16, 1 << 19),
			$urandom_range(1 << 16, 1 << 19));
		hold_req = 1'b1;
		run_random(280);
		drain();

		// Arbitrary rotation rows, shifts and sizes.
		set_canvas(ROW_W'({$urandom, $urandom}), ROW_W'({$urandom, $urandom}),
			ROW_W'({$urandom, $urandom}),
			signed_span(1 << 18), signed_span(1 << 18), signed_span(1 << 18),
			$urandom_range(1, 1 << 20), $urandom_range(1, 1 << 20));
		run_random(280);
		drain();

		// Register extremes: most negative, minus-one and most positive entries, extreme shifts, largest canvas.
		set_canvas(48'h8000_8000_8000, 48'hFFFF_FFFF_FFFF, 48'h7FFF_7FFF_7FFF,
			32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		run_random(200);
		drain();

		// Largest canvas with identity, so huge hits land near the top of the 18-bit pixel range.
		set_canvas(ROT_X_RST, ROT_Y_RST, ROT_Z_RST, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0,
			32'hFFFF_FFFF, 32'hFFFF_FFFF);
		run_random(150);
		drain();

		// Zero-size and one-unit canvases: no hit can fall strictly inside.
		set_canvas(ROT_X_RST, ROT_Y_RST, ROT_Z_RST, 0, 0, 0, 32'h0, 32'h1);
		run_random(100);
		drain();

		// Axis permutation with sign flips and a tall narrow canvas.
		set_canvas(48'h0000_C000_0000, 48'h4000_0000_0000, 48'h0000_0000_C000,
			32'h0002_0000, 32'h0, 32'h0001_0000, 32'h0004_0000, 32'h0010_0000);
		run_random(210);
		drain();

		// Back to the reset values.
		set_canvas(ROT_X_RST, ROT_Y_RST, ROT_Z_RST, 0, 0, 0, SIZE_RST, SIZE_RST);
		run_random(200);
		drain();

		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
